[rtl/drv_arb_pkg.sv]
package drv_arb_pkg;

   localparam int CONFIRM_TICKS_DEF = 5;
   localparam int RELEASE_TICKS_DEF = 5;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int MAG_W  = 28;
   localparam int K_W    = 17;
   localparam int MK_W   = MAG_W + K_W;
   localparam int DEN_W  = 42;
   localparam int PROD_W = 63;
   localparam int NUM_W  = 64;
   localparam int QUO_W  = 29;
   localparam int CNT_W  = $clog2(QUO_W);

   localparam logic [21:0] PI_MICRO  = 22'd3141593;
   localparam logic [17:0] DEG_MILLI = 18'd180000;
   localparam logic [16:0] SERVO_ONE = 17'h10000;

   localparam logic [11:0] LANE_SPEED_RST      = 12'd150;
   localparam logic [15:0] FOLLOW_SPEED_RST    = 16'd1100;
   localparam logic [15:0] MIN_SPEED_RST       = 16'd900;
   localparam logic        KEEP_FORWARD_RST    = 1'b1;
   localparam logic [15:0] SERVO_CENTER_RST    = 16'd35717;
   localparam logic [15:0] YAW_GAIN_RST        = 16'd4915;
   localparam logic [7:0]  LEFT_SCALE_DEG_RST  = 8'd25;
   localparam logic [7:0]  RIGHT_SCALE_DEG_RST = 8'd20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LANE_SPEED      = 3'd0,
      CSR_FOLLOW_SPEED    = 3'd1,
      CSR_MIN_SPEED       = 3'd2,
      CSR_KEEP_FORWARD    = 3'd3,
      CSR_SERVO_CENTER    = 3'd4,
      CSR_YAW_GAIN        = 3'd5,
      CSR_LEFT_SCALE_DEG  = 3'd6,
      CSR_RIGHT_SCALE_DEG = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic capture;
      logic yaw_mul;
      logic scale_mul;
      logic prod_mul;
      logic rnd_load;
      logic div_step;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic need_servo;
   } dp_status_type;

endpackage

[rtl/drive_mode_arbiter_top.sv]
// Drive mode arbiter. One transaction per control tick: a cone detector with
// confirm and release tick counts selects lane mode (linear and angular
// commands) or cone mode (motor speed and a yaw-to-servo position in Q1.16).
// Lane ticks and cone ticks without a valid target go from acceptance to the
// done state, which loads the output register and raises rsp_valid; a cone
// tick with a valid target first passes three multiply steps, a rounding step
// and a bit-serial divider for the servo map. One transaction is processed at
// a time; the next is taken as soon as the result is in the output register,
// even while that result is still stalled. Registers are to be written over
// the csr port while no transaction is in flight; this is not enforced.
module drive_mode_arbiter_top
   import drv_arb_pkg::*;
#(
   parameter int CONFIRM_TICKS = CONFIRM_TICKS_DEF,
   parameter int RELEASE_TICKS = RELEASE_TICKS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cone_seen,
   input  logic                  req_lane_ok,
   input  logic                  req_stop_request,
   input  logic signed [15:0]    req_lane_turn,
   input  logic signed [12:0]    req_target_yaw,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_mode,
   output logic [11:0]           rsp_linear_cmd,
   output logic signed [15:0]    rsp_angular_cmd,
   output logic [15:0]           rsp_motor_cmd,
   output logic [16:0]           rsp_servo_cmd,
   output logic [15:0]           rsp_entry_count
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   drv_arb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   drv_arb_dp #(
      .CONFIRM_TICKS (CONFIRM_TICKS),
      .RELEASE_TICKS (RELEASE_TICKS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_cone_seen    (req_cone_seen),
      .req_lane_ok      (req_lane_ok),
      .req_stop_request (req_stop_request),
      .req_lane_turn    (req_lane_turn),
      .req_target_yaw   (req_target_yaw),
      .rsp_mode         (rsp_mode),
      .rsp_linear_cmd   (rsp_linear_cmd),
      .rsp_angular_cmd  (rsp_angular_cmd),
      .rsp_motor_cmd    (rsp_motor_cmd),
      .rsp_servo_cmd    (rsp_servo_cmd),
      .rsp_entry_count  (rsp_entry_count),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

[rtl/drv_arb_ctrl.sv]
module drv_arb_ctrl
   import drv_arb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_YAW   = 7'b0000010,
      S_SCALE = 7'b0000100,
      S_PROD  = 7'b0001000,
      S_RND   = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.need_servo ? S_YAW : S_DONE;
            end
         end
         S_YAW: begin
            cmd.yaw_mul = 1'b1;
            state_in    = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale_mul = 1'b1;
            state_in      = S_PROD;
         end
         S_PROD: begin
            cmd.prod_mul = 1'b1;
            state_in     = S_RND;
         end
         S_RND: begin
            cmd.rnd_load = 1'b1;
            cnt_in       = CNT_W'(QUO_W - 1);
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/drv_arb_dp.sv]
module drv_arb_dp
   import drv_arb_pkg::*;
#(
   parameter int CONFIRM_TICKS = CONFIRM_TICKS_DEF,
   parameter int RELEASE_TICKS = RELEASE_TICKS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_cone_seen,
   input  logic                  req_lane_ok,
   input  logic                  req_stop_request,
   input  logic signed [15:0]    req_lane_turn,
   input  logic signed [12:0]    req_target_yaw,
   output logic                  rsp_mode,
   output logic [11:0]           rsp_linear_cmd,
   output logic signed [15:0]    rsp_angular_cmd,
   output logic [15:0]           rsp_motor_cmd,
   output logic [16:0]           rsp_servo_cmd,
   output logic [15:0]           rsp_entry_count,
   input  dp_cmd_type            cmd,
   output dp_status_type         status
);

   localparam logic [7:0] CONFIRM_LIM = 8'(CONFIRM_TICKS);
   localparam logic [7:0] RELEASE_LIM = 8'(RELEASE_TICKS);

   logic [11:0] lane_speed_ff;
   logic [15:0] follow_speed_ff;
   logic [15:0] min_speed_ff;
   logic        keep_forward_ff;
   logic [15:0] servo_center_ff;
   logic [15:0] yaw_gain_ff;
   logic [7:0]  left_scale_ff;
   logic [7:0]  right_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_speed_ff   <= LANE_SPEED_RST;
         follow_speed_ff <= FOLLOW_SPEED_RST;
         min_speed_ff    <= MIN_SPEED_RST;
         keep_forward_ff <= KEEP_FORWARD_RST;
         servo_center_ff <= SERVO_CENTER_RST;
         yaw_gain_ff     <= YAW_GAIN_RST;
         left_scale_ff   <= LEFT_SCALE_DEG_RST;
         right_scale_ff  <= RIGHT_SCALE_DEG_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_LANE_SPEED:      lane_speed_ff   <= csr_wdata[11:0];
            CSR_FOLLOW_SPEED:    follow_speed_ff <= csr_wdata;
            CSR_MIN_SPEED:       min_speed_ff    <= csr_wdata;
            CSR_KEEP_FORWARD:    keep_forward_ff <= csr_wdata[0];
            CSR_SERVO_CENTER:    servo_center_ff <= csr_wdata;
            CSR_YAW_GAIN:        yaw_gain_ff     <= csr_wdata;
            CSR_LEFT_SCALE_DEG:  left_scale_ff   <= csr_wdata[7:0];
            CSR_RIGHT_SCALE_DEG: right_scale_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // detector
   logic        on_started_ff, on_started_in;
   logic [7:0]  on_ticks_ff, on_ticks_in;
   logic        ever_seen_ff, ever_seen_in;
   logic [7:0]  off_ticks_ff, off_ticks_in;
   logic        confirmed_ff, confirmed_in;
   logic        prev_mode_ff;
   logic [15:0] entries_ff, entries_in;

   function automatic logic [7:0] sat_inc8(input logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
   endfunction

   always_comb begin
      on_started_in = on_started_ff;
      on_ticks_in   = on_started_ff ? sat_inc8(on_ticks_ff) : on_ticks_ff;
      ever_seen_in  = ever_seen_ff;
      off_ticks_in  = off_ticks_ff;
      confirmed_in  = confirmed_ff;
      if (req_cone_seen) begin
         if (!on_started_ff) begin
            on_started_in = 1'b1;
            on_ticks_in   = 8'd0;
         end
         if (on_ticks_in >= CONFIRM_LIM) begin
            confirmed_in = 1'b1;
         end
         ever_seen_in = 1'b1;
         off_ticks_in = 8'd0;
      end else if (ever_seen_ff) begin
         off_ticks_in = sat_inc8(off_ticks_ff);
         if (off_ticks_in >= RELEASE_LIM) begin
            confirmed_in  = 1'b0;
            on_started_in = 1'b0;
            on_ticks_in   = 8'd0;
         end
      end else begin
         confirmed_in = 1'b0;
      end
      entries_in = entries_ff + 16'(confirmed_in & ~prev_mode_ff);
   end

   assign status.need_servo = confirmed_in & req_cone_seen;

   always_ff @(posedge clock) begin
      if (reset) begin
         on_started_ff <= 1'b0;
         on_ticks_ff   <= '0;
         ever_seen_ff  <= 1'b0;
         off_ticks_ff  <= '0;
         confirmed_ff  <= 1'b0;
         prev_mode_ff  <= 1'b0;
         entries_ff    <= '0;
      end else if (cmd.capture) begin
         on_started_ff <= on_started_in;
         on_ticks_ff   <= on_ticks_in;
         ever_seen_ff  <= ever_seen_in;
         off_ticks_ff  <= off_ticks_in;
         confirmed_ff  <= confirmed_in;
         prev_mode_ff  <= confirmed_in;
         entries_ff    <= entries_in;
      end
   end

   // transaction capture
   logic               seen_ff;
   logic               lane_ok_ff;
   logic               stop_ff;
   logic signed [15:0] turn_ff;
   logic signed [12:0] yaw_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         seen_ff    <= req_cone_seen;
         lane_ok_ff <= req_lane_ok;
         stop_ff    <= req_stop_request;
         turn_ff    <= req_lane_turn;
         yaw_ff     <= req_target_yaw;
      end
   end

   // servo map: multiply steps, then bit-serial rounded divide
   logic signed [29:0] p;
   logic [29:0]        p_abs;
   logic [K_W-1:0]     k;
   logic [7:0]         sc;
   logic [7:0]         sc1;
   logic [29:0]        pi_sc;
   logic [MK_W-1:0]    mk;
   logic [NUM_W-1:0]   num;
   logic [DEN_W:0]     trial;
   logic               ge;

   logic               neg_ff;
   logic [MAG_W-1:0]   mag_ff;
   logic [MK_W-1:0]    mk_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [DEN_W-1:0]   rem_ff;
   logic [QUO_W-1:0]   quo_ff;

   assign p     = 30'(yaw_ff) * 30'($signed({1'b0, yaw_gain_ff}));
   assign p_abs = p[29] ? 30'(-p) : 30'(p);
   assign k     = neg_ff ? {1'b0, servo_center_ff} : SERVO_ONE - {1'b0, servo_center_ff};
   assign sc    = neg_ff ? left_scale_ff : right_scale_ff;
   assign sc1   = (sc == 8'd0) ? 8'd1 : sc;
   assign pi_sc = 30'(PI_MICRO) * 30'(sc1);
   assign mk    = MK_W'(mag_ff) * MK_W'(k);
   assign num   = {1'b0, prod_ff} + {{(NUM_W - DEN_W + 1){1'b0}}, den_ff[DEN_W-1:1]};
   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign ge    = (trial >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (cmd.yaw_mul) begin
         neg_ff <= p[29];
         mag_ff <= p_abs[MAG_W-1:0];
      end
      if (cmd.scale_mul) begin
         mk_ff  <= mk;
         den_ff <= {pi_sc, 12'd0};
      end
      if (cmd.prod_mul) begin
         prod_ff <= PROD_W'(mk_ff) * PROD_W'(DEG_MILLI);
      end
      if (cmd.rnd_load) begin
         rem_ff <= {{(DEN_W - (NUM_W - QUO_W)){1'b0}}, num[NUM_W-1:QUO_W]};
         quo_ff <= num[QUO_W-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_ff <= {quo_ff[QUO_W-2:0], ge};
      end
   end

   logic [QUO_W-1:0] center_w;
   logic [QUO_W:0]   up_sum;
   logic [16:0]      servo_map;

   assign center_w = {{(QUO_W - 16){1'b0}}, servo_center_ff};
   assign up_sum   = {1'b0, center_w} + {1'b0, quo_ff};

   always_comb begin
      if (neg_ff) begin
         servo_map = (quo_ff > center_w) ? 17'd0 : 17'(center_w - quo_ff);
      end else begin
         servo_map = (up_sum > {{(QUO_W - 16){1'b0}}, SERVO_ONE}) ? SERVO_ONE
                                                                  : up_sum[16:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_mode        <= prev_mode_ff;
         rsp_entry_count <= entries_ff;
         rsp_linear_cmd  <= '0;
         rsp_angular_cmd <= '0;
         rsp_motor_cmd   <= '0;
         rsp_servo_cmd   <= '0;
         if (prev_mode_ff) begin
            if (seen_ff) begin
               rsp_motor_cmd <= follow_speed_ff;
               rsp_servo_cmd <= servo_map;
            end else begin
               rsp_motor_cmd <= keep_forward_ff ? min_speed_ff : 16'd0;
               rsp_servo_cmd <= {1'b0, servo_center_ff};
            end
         end else if (lane_ok_ff) begin
            rsp_linear_cmd  <= stop_ff ? 12'd0 : lane_speed_ff;
            rsp_angular_cmd <= turn_ff;
         end
      end
   end

endmodule
